// ----- sv/assert_macros.svh -----
// shared assertion macros for the gcd unit checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/icg_pkg.sv -----
package icg_pkg;

  // request codes
  localparam logic [2:0] REQ_FACT = 3'd0;
  localparam logic [2:0] REQ_FIB  = 3'd1;
  localparam logic [2:0] REQ_COMB = 3'd2;
  localparam logic [2:0] REQ_PERM = 3'd3;
  localparam logic [2:0] REQ_GCD  = 3'd4;

  // status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_RANGE   = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // largest arguments whose results fit 31 bits
  localparam logic [30:0] FACT_MAX = 31'd12;
  localparam logic [30:0] FIB_MAX  = 31'd46;

  // one quotient bit per step
  localparam logic [5:0] DIV_STEPS = 6'd31;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [30:0] operand_a;
    logic [30:0] operand_b;
  } icg_req_t;

  typedef struct packed {
    logic [30:0] value;
    logic [1:0]  status;
  } icg_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FACT,
    ST_FIB,
    ST_PROD,
    ST_GCD,
    ST_DIV,
    ST_DONE
  } icg_state_t;

  // small factorial table, used as the nCr divisor
  function automatic logic [30:0] fact_of(input logic [3:0] n);
    logic [30:0] f;
    unique case (n)
      4'd0:    f = 31'd1;
      4'd1:    f = 31'd1;
      4'd2:    f = 31'd2;
      4'd3:    f = 31'd6;
      4'd4:    f = 31'd24;
      4'd5:    f = 31'd120;
      4'd6:    f = 31'd720;
      4'd7:    f = 31'd5040;
      4'd8:    f = 31'd40320;
      4'd9:    f = 31'd362880;
      4'd10:   f = 31'd3628800;
      4'd11:   f = 31'd39916800;
      4'd12:   f = 31'd479001600;
      default: f = 31'd1;
    endcase
    return f;
  endfunction

endpackage

// ----- sv/integer_combinatorics_gcd_unit.sv -----
// factorial and nPr run the 4-bit multiplier, fibonacci the shared adder; nCr then divides by r!
// and gcd runs one divide per Euclid remainder step, each a pass of the 31-step restoring divider
// one request at a time; busy stays high through the result cycle, and a new request is taken
// only once the sequencer is back in idle
// synchronous active-low reset returns the sequencer to idle; the receiver cannot stall
module integer_combinatorics_gcd_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  icg_pkg::icg_req_t  in_req,
  output logic               out_valid,
  output icg_pkg::icg_res_t  out_result
);

  icg_pkg::icg_state_t state_r, state_nxt;

  logic [30:0] x_r, x_nxt;
  logic [30:0] y_r, y_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [3:0]  b_r, b_nxt;
  logic        comb_r, comb_nxt;
  logic        gcd_mode_r, gcd_mode_nxt;
  logic [30:0] value_r, value_nxt;
  logic [1:0]  status_r, status_nxt;

  logic        accept;
  logic [1:0]  req_status;
  logic [31:0] alu_p, alu_q;
  logic        alu_sub;
  logic [32:0] alu_sum;
  logic        div_ge;
  logic [30:0] rem_new;
  logic [30:0] quo_new;
  logic [34:0] prod;

  assign accept = start && (state_r == icg_pkg::ST_IDLE);

  // operand checks on the incoming transaction
  always_comb begin
    req_status = icg_pkg::STATUS_OK;
    unique case (in_req.req_type)
      icg_pkg::REQ_FACT: begin
        if (in_req.operand_a > icg_pkg::FACT_MAX) req_status = icg_pkg::STATUS_RANGE;
      end
      icg_pkg::REQ_FIB: begin
        if (in_req.operand_a > icg_pkg::FIB_MAX) req_status = icg_pkg::STATUS_RANGE;
      end
      icg_pkg::REQ_COMB, icg_pkg::REQ_PERM: begin
        if (in_req.operand_b > in_req.operand_a) begin
          req_status = icg_pkg::STATUS_INVALID;
        end else if (in_req.operand_a > icg_pkg::FACT_MAX) begin
          req_status = icg_pkg::STATUS_RANGE;
        end
      end
      icg_pkg::REQ_GCD: begin
        if (in_req.operand_b == 31'd0) req_status = icg_pkg::STATUS_INVALID;
      end
      default: req_status = icg_pkg::STATUS_INVALID;
    endcase
  end

  // shared add/subtract unit: fibonacci add or divider trial subtract
  always_comb begin
    if (state_r == icg_pkg::ST_DIV) begin
      alu_p   = {rem_r, x_r[30]};
      alu_q   = {1'b0, y_r};
      alu_sub = 1'b1;
    end else begin
      alu_p   = {1'b0, x_r};
      alu_q   = {1'b0, y_r};
      alu_sub = 1'b0;
    end
  end

  assign alu_sum = {1'b0, alu_p} + {1'b0, alu_q ^ {32{alu_sub}}} + {32'd0, alu_sub};
  assign div_ge  = alu_sum[32];
  assign rem_new = div_ge ? alu_sum[30:0] : alu_p[30:0];
  assign quo_new = {x_r[29:0], div_ge};

  // small multiplier: running product times a 4-bit factor
  assign prod = {4'd0, x_r} * {31'd0, k_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      icg_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_status != icg_pkg::STATUS_OK) begin
            state_nxt = icg_pkg::ST_DONE;
          end else begin
            unique case (in_req.req_type)
              icg_pkg::REQ_FACT: state_nxt = icg_pkg::ST_FACT;
              icg_pkg::REQ_FIB: begin
                state_nxt = (in_req.operand_a == 31'd0) ? icg_pkg::ST_DONE : icg_pkg::ST_FIB;
              end
              icg_pkg::REQ_COMB, icg_pkg::REQ_PERM: state_nxt = icg_pkg::ST_PROD;
              icg_pkg::REQ_GCD:  state_nxt = icg_pkg::ST_GCD;
              default:           state_nxt = icg_pkg::ST_DONE;
            endcase
          end
        end
      end
      icg_pkg::ST_FACT: begin
        if (k_r <= 4'd1) state_nxt = icg_pkg::ST_DONE;
      end
      icg_pkg::ST_FIB: begin
        if (cnt_r == 6'd0) state_nxt = icg_pkg::ST_DONE;
      end
      icg_pkg::ST_PROD: begin
        if (cnt_r == 6'd0) state_nxt = comb_r ? icg_pkg::ST_DIV : icg_pkg::ST_DONE;
      end
      icg_pkg::ST_GCD: begin
        state_nxt = (y_r == 31'd0) ? icg_pkg::ST_DONE : icg_pkg::ST_DIV;
      end
      icg_pkg::ST_DIV: begin
        if (cnt_r == 6'd1) state_nxt = gcd_mode_r ? icg_pkg::ST_GCD : icg_pkg::ST_DONE;
      end
      icg_pkg::ST_DONE: state_nxt = icg_pkg::ST_IDLE;
      default:          state_nxt = icg_pkg::ST_IDLE;
    endcase
  end

  // datapath updates per sequencer step
  always_comb begin
    x_nxt        = x_r;
    y_nxt        = y_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    b_nxt        = b_r;
    comb_nxt     = comb_r;
    gcd_mode_nxt = gcd_mode_r;
    value_nxt    = value_r;
    status_nxt   = status_r;
    unique case (state_r)
      icg_pkg::ST_IDLE: begin
        if (accept) begin
          value_nxt    = 31'd0;
          status_nxt   = req_status;
          x_nxt        = 31'd1;
          y_nxt        = 31'd1;
          k_nxt        = in_req.operand_a[3:0];
          b_nxt        = in_req.operand_b[3:0];
          cnt_nxt      = {2'd0, in_req.operand_b[3:0]};
          comb_nxt     = (in_req.req_type == icg_pkg::REQ_COMB);
          gcd_mode_nxt = 1'b0;
          if (in_req.req_type == icg_pkg::REQ_FIB) begin
            x_nxt   = 31'd0;
            cnt_nxt = in_req.operand_a[5:0] - 6'd1;
          end else if (in_req.req_type == icg_pkg::REQ_GCD) begin
            x_nxt        = in_req.operand_a;
            y_nxt        = in_req.operand_b;
            gcd_mode_nxt = 1'b1;
          end
        end
      end
      icg_pkg::ST_FACT: begin
        if (k_r > 4'd1) begin
          x_nxt = prod[30:0];
          k_nxt = k_r - 4'd1;
        end else begin
          value_nxt = x_r;
        end
      end
      icg_pkg::ST_FIB: begin
        if (cnt_r != 6'd0) begin
          x_nxt   = y_r;
          y_nxt   = alu_sum[30:0];
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          value_nxt = y_r;
        end
      end
      icg_pkg::ST_PROD: begin
        if (cnt_r != 6'd0) begin
          x_nxt   = prod[30:0];
          k_nxt   = k_r - 4'd1;
          cnt_nxt = cnt_r - 6'd1;
        end else if (comb_r) begin
          // nCr: divide the falling product by r!
          y_nxt   = icg_pkg::fact_of(b_r);
          rem_nxt = 31'd0;
          cnt_nxt = icg_pkg::DIV_STEPS;
        end else begin
          value_nxt = x_r;
        end
      end
      icg_pkg::ST_GCD: begin
        if (y_r != 31'd0) begin
          rem_nxt = 31'd0;
          cnt_nxt = icg_pkg::DIV_STEPS;
        end else begin
          value_nxt = x_r;
        end
      end
      icg_pkg::ST_DIV: begin
        rem_nxt = rem_new;
        x_nxt   = quo_new;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          if (gcd_mode_r) begin
            // euclid step: (x, y) becomes (y, x mod y)
            x_nxt = y_r;
            y_nxt = rem_new;
          end else begin
            value_nxt = quo_new;
          end
        end
      end
      icg_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= icg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    b_r        <= b_nxt;
    comb_r     <= comb_nxt;
    gcd_mode_r <= gcd_mode_nxt;
    value_r    <= value_nxt;
    status_r   <= status_nxt;
  end

  // outputs
  always_comb begin
    busy              = (state_r != icg_pkg::ST_IDLE);
    out_valid         = (state_r == icg_pkg::ST_DONE);
    out_result.value  = value_r;
    out_result.status = status_r;
  end

endmodule

// ----- sv/icg_checker.sv -----
`include "assert_macros.svh"

module icg_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input icg_pkg::icg_req_t in_req,
  input logic              out_valid,
  input icg_pkg::icg_res_t out_result
);

  logic req_seen;
  logic err_zero;
  logic status_legal;

  assign req_seen     = start && !busy;
  assign err_zero     = (out_result.status == icg_pkg::STATUS_OK) || (out_result.value == 31'd0);
  assign status_legal = (out_result.status == icg_pkg::STATUS_OK) ||
                        (out_result.status == icg_pkg::STATUS_RANGE) ||
                        (out_result.status == icg_pkg::STATUS_INVALID);

  property p_strobe_pulse;
    out_valid |-> busy ##1 !out_valid;
  endproperty

  property p_busy_end;
    $fell(busy) && $past(rst_n) |-> $past(out_valid);
  endproperty

  // an accepted transaction keeps the unit busy until its result
  `ASSERT_CLK(a_accept_busy, clk, rst_n, req_seen |=> busy, "busy not raised on accept")

  // a result is strobed for one cycle only, while still busy
  `ASSERT_CLK(a_strobe_pulse, clk, rst_n, p_strobe_pulse, "result strobe not a single busy cycle")

  // busy drops only right after a result was delivered
  `ASSERT_CLK(a_busy_end, clk, rst_n, p_busy_end, "busy fell without a result")

  // error results carry a zero value, and every result has a legal status
  `ASSERT_CLK(a_err_value, clk, rst_n, out_valid |-> err_zero && status_legal, "bad error result")

endmodule

bind integer_combinatorics_gcd_unit icg_checker u_icg_checker (.*);

// ----- bench/integer_combinatorics_gcd_unit_checker.sv -----
module integer_combinatorics_gcd_unit_checker
  import icg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  icg_req_t  in_req,
  input  logic      out_valid,
  input  icg_res_t  out_result,
  output int        mismatches,
  output int        outstanding
);

  // results owed by the block, oldest first
  icg_res_t awaited_results[$];
  icg_res_t oldest;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // n! for the small arguments that the range checks let through
  function automatic logic [31:0] factorial(input int unsigned n);
    logic [31:0] f;
    f = 32'd1;
    for (int unsigned k = 2; k <= n; k++) f = f * k;
    return f;
  endfunction

  // value and status that one request must produce
  function automatic icg_res_t evaluate_request(input icg_req_t req);
    icg_res_t    res;
    logic [31:0] prev, cur, nxt, x, y, t, denom;
    res.value  = '0;
    res.status = STATUS_OK;
    case (req.req_type)
      REQ_FACT: begin
        if (req.operand_a > FACT_MAX) res.status = STATUS_RANGE;
        else res.value = 31'(factorial(req.operand_a));
      end
      REQ_FIB: begin
        if (req.operand_a > FIB_MAX) begin
          res.status = STATUS_RANGE;
        end else if (req.operand_a != '0) begin
          prev = 32'd0;
          cur  = 32'd1;
          for (int unsigned k = 1; k < req.operand_a; k++) begin
            nxt  = prev + cur;
            prev = cur;
            cur  = nxt;
          end
          res.value = 31'(cur);
        end
      end
      REQ_COMB, REQ_PERM: begin
        // r above n is checked ahead of the range limit
        if (req.operand_b > req.operand_a) begin
          res.status = STATUS_INVALID;
        end else if (req.operand_a > FACT_MAX) begin
          res.status = STATUS_RANGE;
        end else begin
          denom = factorial(req.operand_a - req.operand_b);
          if (req.req_type == REQ_COMB) denom = denom * factorial(req.operand_b);
          res.value = 31'(factorial(req.operand_a) / denom);
        end
      end
      REQ_GCD: begin
        if (req.operand_b == '0) begin
          res.status = STATUS_INVALID;
        end else begin
          x = 32'(req.operand_a);
          y = 32'(req.operand_b);
          while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
          end
          res.value = 31'(x);
        end
      end
      default: res.status = STATUS_INVALID;
    endcase
    return res;
  endfunction

  // compare each strobed result, then queue the prediction for a new transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unrequested result value=%0d status=%0d",
                                    out_result.value, out_result.status));
        end else begin
          oldest = awaited_results.pop_front();
          if (out_result.value !== oldest.value)
            report_mismatch($sformatf("value %0d, want %0d",
                                      out_result.value, oldest.value));
          if (out_result.status !== oldest.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_result.status, oldest.status));
        end
      end
      if (start && !busy) awaited_results.push_back(evaluate_request(in_req));
      outstanding = awaited_results.size();
    end
  end

endmodule

// ----- bench/integer_combinatorics_gcd_unit_tb.sv -----
module integer_combinatorics_gcd_unit_tb;
  import icg_pkg::*;

  localparam int RANDOM_ITEMS = 1930;
  localparam int DRAIN_CYCLES = 2000;
  localparam int CYCLE_LIMIT  = 20_000_000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  icg_req_t in_req;
  logic     out_valid;
  icg_res_t out_result;
  int       mismatches;
  int       outstanding;
  int       cycle_count;

  integer_combinatorics_gcd_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  integer_combinatorics_gcd_unit_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_result  (out_result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cycle_count = 0;
  end

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integer_combinatorics_gcd_unit regression: fail");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 200);
  endfunction

  // drop start for the given gap, then present one transaction until it is taken
  task automatic send_request(input logic [2:0] op, input logic [30:0] a,
                              input logic [30:0] b, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_req <= '{req_type: op, operand_a: a, operand_b: b};
    do @(posedge clk); while (busy);
  endtask

  // hold off until the block has returned everything
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [30:0] any_operand();
    return 31'($urandom);
  endfunction

  // random request, weighted toward operands that reach the computing paths
  task automatic send_random(input int gap);
    logic [2:0]  op;
    logic [30:0] a, b;
    int          r;
    r = $urandom_range(0, 99);
    b = any_operand();
    if (r < 18) begin
      op = REQ_FACT;
      a = ($urandom_range(0, 9) < 8) ? 31'($urandom_range(0, 15)) : any_operand();
    end else if (r < 36) begin
      op = REQ_FIB;
      a = ($urandom_range(0, 9) < 8) ? 31'($urandom_range(0, 50)) : any_operand();
    end else if (r < 74) begin
      op = (r < 56) ? REQ_COMB : REQ_PERM;
      if ($urandom_range(0, 9) < 8) begin
        a = 31'($urandom_range(0, 14));
        b = 31'($urandom_range(0, a + 2));
      end else begin
        a = any_operand();
      end
    end else if (r < 94) begin
      op = REQ_GCD;
      case ($urandom_range(0, 9))
        0:       begin
          a = any_operand();
          b = '0;
        end
        1:       a = '0;
        2, 3:    begin
          a = any_operand();
          b = 31'($urandom_range(1, 1000)) * 31'($urandom_range(1, 1000));
        end
        4, 5, 6: begin
          a = 31'($urandom_range(0, 5000));
          b = 31'($urandom_range(0, 5000));
        end
        default: a = any_operand();
      endcase
      if (a == 0 && b == 0 && $urandom_range(0, 1)) b = 31'($urandom_range(1, 99));
    end else begin
      op = 3'($urandom_range(REQ_GCD + 1, 3'h7));
      a = any_operand();
    end
    send_request(op, a, b, gap);
  endtask

  // stimulus
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_request(REQ_FACT, '0, '1, 0);
    send_request(REQ_FACT, FACT_MAX, '0, 1);
    send_request(REQ_FACT, FACT_MAX + 1, '0, 0);
    send_request(REQ_FACT, '1, '1, 0);
    send_request(REQ_FIB, '0, '0, 2);
    send_request(REQ_FIB, 31'd1, '1, 0);
    send_request(REQ_FIB, FIB_MAX, '0, 0);
    send_request(REQ_FIB, FIB_MAX + 1, '0, 5);
    send_request(REQ_COMB, FACT_MAX, 31'd6, 0);
    send_request(REQ_COMB, '0, '0, 0);
    send_request(REQ_COMB, 31'd5, 31'd7, 3);
    send_request(REQ_COMB, FACT_MAX + 1, 31'd2, 0);
    send_request(REQ_COMB, '1, '1, 0);
    send_request(REQ_PERM, FACT_MAX, FACT_MAX, 1);
    send_request(REQ_PERM, FACT_MAX, '0, 0);
    send_request(REQ_PERM, 31'd3, '1, 0);
    send_request(REQ_PERM, '1, 31'd1, 0);
    send_request(REQ_GCD, '0, 31'd5, 0);
    send_request(REQ_GCD, '1, '0, 2);
    send_request(REQ_GCD, '1, '1, 0);
    send_request(REQ_GCD, 31'd1836311903, 31'd1134903170, 0);
    send_request(REQ_GCD, 31'd12, 31'd18, 0);
    send_request(REQ_GCD + 3'd1, '1, '1, 0);
    send_request(REQ_GCD + 3'd2, '0, '0, 0);
    send_request(3'h7, '1, '0, 0);
    drain_results();

    // random traffic, with back-to-back stretches and one mid-run drain
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_results();
      send_random((((i / 60) % 4) == 1) ? 0 : pick_gap());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("integer_combinatorics_gcd_unit regression: pass");
    end else begin
      $display("integer_combinatorics_gcd_unit regression: fail");
    end
    $finish;
  end

endmodule
